### rtl/core/pcnt_pkg.sv
// Shared constants, token type and elaboration helpers for the prime counter.
package pcnt_pkg;

   localparam int LIMIT_BITS = 17;

   localparam longint MAX_LIMIT = (64'sd1 <<< LIMIT_BITS) - 64'sd1;

   function automatic longint isqrt(longint v);
      longint r;
      r = 0;
      while ((r + 1) * (r + 1) <= v) begin
         r = r + 1;
      end
      return r;
   endfunction

   localparam longint SQRT_MAX = isqrt(MAX_LIMIT);

   // one cell per odd divisor 7, 9, 11, ... up to sqrt(MAX_LIMIT)
   localparam int NUM_CELLS = (SQRT_MAX >= 7) ? int'((SQRT_MAX - 7) / 2 + 1) : 1;
   localparam int DIV_MAX   = 7 + 2 * (NUM_CELLS - 1);
   localparam int RES_BITS  = $clog2(DIV_MAX + 2);

   localparam int TDATA_W = 8 * ((LIMIT_BITS + 7) / 8);

   localparam logic [RES_BITS-1:0]   START_RES = RES_BITS'(3);
   localparam logic [LIMIT_BITS-1:0] FIRST_CAND = LIMIT_BITS'(3);

   typedef struct packed {
      logic                  valid;
      logic                  first;
      logic                  last;
      logic                  skip;
      logic [LIMIT_BITS-1:0] cand;
   } tok_type;

endpackage

### rtl/core/prime_counter_top.sv
// Top level of the prime counter: generator, divisor cell chain and tally.
//
// One item carries a limit N; the block answers with the number of primes p, 2 <= p <= N.
// Odd candidates from 3 up to N leave the generator one per cycle and stream through a
// chain of 178 divisor cells (odd divisors 7 to 361), each keeping the running residue
// of the candidate stream modulo its divisor. The result appears after the last candidate
// has passed every cell of the chain and the tally; the walk of one candidate per cycle and
// the length of the cell chain set how long an item takes.
// A new item is taken the cycle after the previous result enters the output register;
// while that register still holds an unread result, a finished count waits and the
// input stalls with it.
module prime_counter_top import pcnt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,   // [16:0] limit
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata    // [16:0] prime_count
);

   tok_type               chain [NUM_CELLS+1];
   logic                  busy;
   logic                  done;
   logic [LIMIT_BITS-1:0] lim;
   logic [LIMIT_BITS-1:0] rsp_data;
   logic                  start;

   assign req_tready = !busy;
   assign start      = req_tvalid && req_tready;

   pcnt_gen u_gen (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .limit  (req_tdata[LIMIT_BITS-1:0]),
      .done   (done),
      .tok    (chain[0]),
      .busy   (busy),
      .lim    (lim)
   );

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      localparam longint DIV = 7 + 2 * i;
      localparam longint SQ  = DIV * DIV;
      localparam logic   OK  = (SQ <= MAX_LIMIT);

      pcnt_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .div    (RES_BITS'(DIV)),
         .div_sq (OK ? LIMIT_BITS'(SQ) : '0),
         .usable (OK),
         .up_tok (chain[i]),
         .dn_tok (chain[i+1])
      );
   end

   pcnt_tally u_tally (
      .clock     (clock),
      .reset     (reset),
      .tok       (chain[NUM_CELLS]),
      .lim       (lim),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_data  (rsp_data),
      .done      (done)
   );

   assign rsp_tdata = TDATA_W'(rsp_data);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start |=> !req_tready)
      else $error("block not busy after taking an item");

   a_tail_while_busy: assert property (@(posedge clock) disable iff (reset)
      chain[NUM_CELLS].valid |-> busy)
      else $error("candidate reached tally while idle");

   a_first_is_three: assert property (@(posedge clock) disable iff (reset)
      (chain[0].valid && chain[0].first) |-> (chain[0].cand == FIRST_CAND))
      else $error("first candidate is not 3");

   a_done_needs_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> busy)
      else $error("result released while idle");

endmodule

### rtl/core/pcnt_gen.sv
// Candidate generator: walks odd numbers from 3 to the limit, flags multiples of 3 and 5.
module pcnt_gen import pcnt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [LIMIT_BITS-1:0] limit,
   input  logic                  done,
   output tok_type               tok,
   output logic                  busy,
   output logic [LIMIT_BITS-1:0] lim
);

   logic                  run_ff,   run_in;
   logic                  first_ff, first_in;
   logic                  busy_ff,  busy_in;
   logic [LIMIT_BITS-1:0] cand_ff,  cand_in;
   logic [LIMIT_BITS-1:0] lim_ff,   lim_in;
   logic [1:0]            m3_ff,    m3_in;
   logic [2:0]            m5_ff,    m5_in;
   logic [LIMIT_BITS:0]   next2;
   logic [2:0]            m5_sum;
   logic                  at_end;

   always_comb begin
      next2  = {1'b0, cand_ff} + (LIMIT_BITS + 1)'(2);
      at_end = next2 > {1'b0, lim_ff};
      m5_sum = m5_ff + 3'd2;

      tok.valid = run_ff;
      tok.first = first_ff;
      tok.last  = at_end;
      tok.skip  = (m3_ff == 2'd0) || (m5_ff == 3'd0);
      tok.cand  = cand_ff;

      run_in   = run_ff;
      first_in = first_ff;
      busy_in  = busy_ff;
      cand_in  = cand_ff;
      lim_in   = lim_ff;
      m3_in    = m3_ff;
      m5_in    = m5_ff;

      if (start) begin
         run_in   = 1'b1;
         first_in = 1'b1;
         busy_in  = 1'b1;
         cand_in  = FIRST_CAND;
         lim_in   = limit;
         m3_in    = 2'd0;
         m5_in    = 3'd3;
      end else if (run_ff) begin
         first_in = 1'b0;
         cand_in  = next2[LIMIT_BITS-1:0];
         m3_in    = (m3_ff == 2'd0) ? 2'd2 : m3_ff - 2'd1;
         m5_in    = (m5_sum >= 3'd5) ? m5_sum - 3'd5 : m5_sum;
         if (at_end) begin
            run_in = 1'b0;
         end
      end

      if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         busy_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         busy_ff <= busy_in;
      end
      first_ff <= first_in;
      cand_ff  <= cand_in;
      lim_ff   <= lim_in;
      m3_ff    <= m3_in;
      m5_ff    <= m5_in;
   end

   assign busy = busy_ff;
   assign lim  = lim_ff;

endmodule

### rtl/core/pcnt_cell.sv
// Divisor cell: tracks candidate residue mod its divisor and marks divisible candidates.
module pcnt_cell import pcnt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [RES_BITS-1:0]   div,
   input  logic [LIMIT_BITS-1:0] div_sq,
   input  logic                  usable,
   input  tok_type               up_tok,
   output tok_type               dn_tok
);

   tok_type               tok_ff, tok_in;
   logic [RES_BITS-1:0]   res_ff, res_in;
   logic [RES_BITS-1:0]   res_cur;
   logic [RES_BITS-1:0]   res_sum;
   logic                  hit;

   always_comb begin
      res_cur = up_tok.first ? START_RES : res_ff;
      res_sum = res_cur + RES_BITS'(2);
      // divisor counts only once its square has been reached
      hit     = up_tok.valid && usable && (up_tok.cand >= div_sq) && (res_cur == '0);

      tok_in      = up_tok;
      tok_in.skip = up_tok.skip || hit;

      res_in = res_ff;
      if (up_tok.valid) begin
         res_in = (res_sum >= div) ? res_sum - div : res_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.first <= tok_in.first;
      tok_ff.last  <= tok_in.last;
      tok_ff.skip  <= tok_in.skip;
      tok_ff.cand  <= tok_in.cand;
      res_ff       <= res_in;
   end

   assign dn_tok = tok_ff;

endmodule

### rtl/core/pcnt_tally.sv
// Tally: counts surviving candidates, adds those of 2, 3 and 5 not above the limit, and holds the result item.
module pcnt_tally import pcnt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  tok_type               tok,
   input  logic [LIMIT_BITS-1:0] lim,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [LIMIT_BITS-1:0] rsp_data,
   output logic                  done
);

   logic [LIMIT_BITS-1:0] cnt_ff,       cnt_in;
   logic [LIMIT_BITS-1:0] res_ff,       res_in;
   logic                  hold_ff,      hold_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LIMIT_BITS-1:0] rsp_data_ff,  rsp_data_in;
   logic [LIMIT_BITS-1:0] cnt_new;
   logic [LIMIT_BITS-1:0] base;
   logic                  take;

   always_comb begin
      base = LIMIT_BITS'(lim >= LIMIT_BITS'(2))
           + LIMIT_BITS'(lim >= LIMIT_BITS'(3))
           + LIMIT_BITS'(lim >= LIMIT_BITS'(5));

      cnt_new = (tok.first ? '0 : cnt_ff) + LIMIT_BITS'(!tok.skip);

      take = hold_ff && (!rsp_valid_ff || rsp_ready);

      cnt_in       = cnt_ff;
      res_in       = res_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (tok.valid) begin
         cnt_in = cnt_new;
         if (tok.last) begin
            res_in  = cnt_new + base;
            hold_in = 1'b1;
         end
      end

      if (take) begin
         hold_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff      <= cnt_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign done      = take;

endmodule
